@@ rtl/core/ffba_pkg.sv @@
// Shared constants, codes and control structs of the first-fit block allocator.
package ffba_pkg;

	localparam int DEF_TABLE_ENTRIES = 64;
	localparam int DEF_ADDR_BITS     = 32;

	localparam int DATA_W   = 32;
	localparam int LEN_W    = 32;
	localparam int KIND_W   = 2;
	localparam int STATUS_W = 2;
	localparam int USED_W   = 7;
	localparam int CFG_IDX_W = 4;

	localparam logic [DATA_W-1:0] RESET_BASE = 32'h0000_1000;
	localparam logic [DATA_W-1:0] RESET_SIZE = 32'h0001_0000;

	localparam logic [KIND_W-1:0] KIND_ALLOC  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_FREE   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_INIT   = 2'd2;
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_ZERO     = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOFIT    = 2'd2;
	localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_HEAP_BASE = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEAP_SIZE = 4'd1;

	typedef struct packed {
		logic                latch;
		logic                scan;
		logic                next_cap;
		logic                mv_start;
		logic                fix_a;
		logic                fix_b;
		logic                fin;
		logic [STATUS_W-1:0] fin_code;
	} ffba_cmd_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic              req_zero;
		logic              addr_zero;
		logic              full;
		logic              hit;
		logic              miss;
		logic              mv_done;
		logic              need_b;
	} ffba_sts_t;

endpackage

@@ rtl/core/ffba_ram.sv @@
// Generic simple dual-port RAM with registered read.
module ffba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ rtl/core/ffba_ctrl.sv @@
// Controller state machine of the first-fit block allocator.
module ffba_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	output logic              done,
	output ffba_pkg::ffba_cmd_t cmd,
	input  ffba_pkg::ffba_sts_t sts
);
	import ffba_pkg::*;

	typedef enum logic [3:0] {
		S_INIT, S_IDLE, S_DISP, S_SCAN, S_NEXT, S_MSET, S_MOVE, S_FIXA, S_FIXB
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_INIT: begin
				cmd.fix_a = 1'b1;
				state_d   = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					cmd.latch = 1'b1;
					state_d   = S_DISP;
				end
			end
			S_DISP: begin
				unique case (sts.kind)
					KIND_ALLOC: begin
						if (sts.req_zero) begin
							cmd.fin = 1'b1; cmd.fin_code = ST_ZERO; state_d = S_IDLE;
						end else if (sts.full) begin
							cmd.fin = 1'b1; cmd.fin_code = ST_NOFIT; state_d = S_IDLE;
						end else begin
							state_d = S_SCAN;
						end
					end
					KIND_FREE: begin
						if (sts.addr_zero) begin
							cmd.fin = 1'b1; cmd.fin_code = ST_ZERO; state_d = S_IDLE;
						end else begin
							state_d = S_SCAN;
						end
					end
					KIND_INIT: state_d = S_FIXA;
					default: begin
						cmd.fin = 1'b1; cmd.fin_code = ST_OK; state_d = S_IDLE;
					end
				endcase
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.hit) begin
					state_d = (sts.kind == KIND_FREE) ? S_NEXT : S_MSET;
				end else if (sts.miss) begin
					cmd.fin      = 1'b1;
					cmd.fin_code = (sts.kind == KIND_FREE) ? ST_NOTFOUND : ST_NOFIT;
					state_d      = S_IDLE;
				end
			end
			S_NEXT: begin
				cmd.next_cap = 1'b1;
				state_d      = S_MSET;
			end
			S_MSET: begin
				cmd.mv_start = 1'b1;
				state_d      = S_MOVE;
			end
			S_MOVE: begin
				if (sts.mv_done) begin
					state_d = S_FIXA;
				end
			end
			S_FIXA: begin
				cmd.fix_a = 1'b1;
				if (sts.need_b) begin
					state_d = S_FIXB;
				end else begin
					cmd.fin = 1'b1; cmd.fin_code = ST_OK; state_d = S_IDLE;
				end
			end
			S_FIXB: begin
				cmd.fix_b = 1'b1;
				cmd.fin   = 1'b1;
				cmd.fin_code = ST_OK;
				state_d   = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			done    <= 1'b0;
		end else begin
			state_q <= state_d;
			done    <= cmd.fin;
		end
	end

	assign busy = (state_q != S_IDLE);
endmodule

@@ rtl/core/ffba_dpath.sv @@
// Datapath of the first-fit block allocator: table RAM, scan, move engine, fix-up writes.
module ffba_dpath #(
	parameter int TABLE_ENTRIES = ffba_pkg::DEF_TABLE_ENTRIES,
	parameter int ADDR_BITS     = ffba_pkg::DEF_ADDR_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  ffba_pkg::ffba_cmd_t                 cmd,
	output ffba_pkg::ffba_sts_t                 sts,
	input  logic [ffba_pkg::KIND_W-1:0]         kind,
	input  logic [ffba_pkg::DATA_W-1:0]         request_size,
	input  logic [ffba_pkg::DATA_W-1:0]         block_address,
	input  logic                                cfg_we,
	input  logic [ffba_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ffba_pkg::DATA_W-1:0]         cfg_data,
	output logic [ffba_pkg::DATA_W-1:0]         address,
	output logic [ffba_pkg::STATUS_W-1:0]       status,
	output logic [ffba_pkg::USED_W-1:0]         entries_in_use
);
	import ffba_pkg::*;

	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
	localparam int PW    = CNT_W + 1;
	localparam int W     = ADDR_BITS + LEN_W + 1;

	logic [DATA_W-1:0]    base_q, size_q;
	logic [KIND_W-1:0]    kind_q;
	logic [LEN_W-1:0]     req_q;
	logic [ADDR_BITS-1:0] baddr_q;
	logic [CNT_W-1:0]     count_q;
	logic [PW-1:0]        ptr_q, tag_s1, hit_idx_q;
	logic                 live_s1, vld_s1;
	logic [W-1:0]         hit_q, prev_q, nxt_q;
	logic                 nxt_vld_q;
	logic                 mv_act_q, mv_down_q, wr_pend_s1;
	logic [PW-1:0]        mv_cur_q, mv_end_q, wr_idx_s1;
	logic [1:0]           mv_dist_q;
	logic [DATA_W-1:0]    addr_q;
	logic [STATUS_W-1:0]  status_q;

	logic [W-1:0]         rdata, wdata;
	logic                 we;
	logic [IDX_W-1:0]     waddr, raddr;

	logic [ADDR_BITS-1:0] rd_start, hit_start, prev_start;
	logic [LEN_W-1:0]     rd_len, hit_len, prev_len, nxt_len;
	logic                 rd_taken, prev_taken, nxt_taken;
	logic                 match, hit_now, split, pf, nf;
	logic [PW-1:0]        cnt_w, mv_first, mv_last, fa_idx;
	logic                 mv_empty;
	logic [1:0]           mv_dist;
	logic [W-1:0]         fa_data, fb_data;
	logic [LEN_W-1:0]     merge_len;

	assign {rd_start, rd_len, rd_taken}     = rdata;
	assign hit_start                        = hit_q[W-1 -: ADDR_BITS];
	assign hit_len                          = hit_q[LEN_W:1];
	assign prev_start                       = prev_q[W-1 -: ADDR_BITS];
	assign prev_len                         = prev_q[LEN_W:1];
	assign prev_taken                       = prev_q[0];
	assign nxt_len                          = nxt_q[LEN_W:1];
	assign nxt_taken                        = nxt_q[0];
	assign cnt_w                            = PW'(count_q);

	assign match   = (kind_q == KIND_FREE) ? (rd_taken && (rd_start == baddr_q))
	                                       : (!rd_taken && (rd_len >= req_q));
	assign hit_now = cmd.scan && live_s1 && vld_s1 && match;
	assign split   = {1'b0, hit_len} > {req_q, 1'b0};
	assign pf      = (hit_idx_q != '0) && !prev_taken;
	assign nf      = nxt_vld_q && !nxt_taken;

	always_comb begin
		mv_dist   = 2'd1;
		mv_first  = cnt_w - PW'(1);
		mv_last   = hit_idx_q + PW'(1);
		mv_empty  = 1'b1;
		merge_len = hit_len + (nf ? nxt_len : '0);
		fa_idx    = hit_idx_q;
		fa_data   = {hit_start, hit_len, 1'b1};
		fb_data   = {hit_start, req_q, 1'b1};
		unique case (kind_q)
			KIND_ALLOC: begin
				mv_empty = !split || ((hit_idx_q + PW'(2)) > cnt_w);
				if (split) begin
					fa_idx  = hit_idx_q + PW'(1);
					fa_data = {hit_start + ADDR_BITS'(req_q), hit_len - req_q, 1'b0};
				end
			end
			KIND_FREE: begin
				mv_dist  = (pf && nf) ? 2'd2 : 2'd1;
				mv_first = hit_idx_q + (nf ? PW'(2) : PW'(1));
				mv_last  = cnt_w - PW'(1);
				mv_empty = !(pf || nf) || (mv_first >= cnt_w);
				if (pf) begin
					fa_idx  = hit_idx_q - PW'(1);
					fa_data = {prev_start, prev_len + merge_len, 1'b0};
				end else begin
					fa_data = {hit_start, merge_len, 1'b0};
				end
			end
			KIND_INIT: begin
				fa_idx  = '0;
				fa_data = {ADDR_BITS'(base_q), LEN_W'(size_q), 1'b0};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q     <= RESET_BASE;
			size_q     <= RESET_SIZE;
			kind_q     <= KIND_INIT;
			count_q    <= CNT_W'(1);
			ptr_q      <= '0;
			live_s1    <= 1'b0;
			vld_s1     <= 1'b0;
			mv_act_q   <= 1'b0;
			wr_pend_s1 <= 1'b0;
			nxt_vld_q  <= 1'b0;
			status_q   <= ST_OK;
			addr_q     <= '0;
		end else begin
			if (cfg_we && cfg_index == REG_HEAP_BASE) base_q <= cfg_data;
			if (cfg_we && cfg_index == REG_HEAP_SIZE) size_q <= cfg_data;
			if (cmd.latch) begin
				kind_q <= kind;
				ptr_q  <= '0;
			end else if (cmd.scan) begin
				ptr_q <= ptr_q + PW'(1);
			end
			live_s1 <= cmd.scan;
			vld_s1  <= cmd.scan && (ptr_q < cnt_w);
			if (cmd.next_cap) nxt_vld_q <= vld_s1;
			if (cmd.mv_start) begin
				mv_act_q <= !mv_empty;
			end else if (mv_act_q && mv_cur_q == mv_end_q) begin
				mv_act_q <= 1'b0;
			end
			wr_pend_s1 <= mv_act_q;
			if (cmd.fix_a) begin
				unique case (kind_q)
					KIND_INIT:  count_q <= CNT_W'(1);
					KIND_ALLOC: count_q <= count_q + (split ? CNT_W'(1) : '0);
					KIND_FREE:  count_q <= count_q - CNT_W'(pf) - CNT_W'(nf);
					default: ;
				endcase
			end
			if (cmd.fin) begin
				status_q <= cmd.fin_code;
				addr_q   <= (cmd.fin_code == ST_OK && kind_q == KIND_ALLOC)
				            ? DATA_W'(hit_start) : '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			req_q   <= request_size;
			baddr_q <= ADDR_BITS'(block_address);
		end
		tag_s1 <= ptr_q;
		if (hit_now) begin
			hit_q     <= rdata;
			hit_idx_q <= tag_s1;
		end else if (cmd.scan && live_s1 && vld_s1) begin
			prev_q <= rdata;
		end
		if (cmd.next_cap) nxt_q <= rdata;
		if (cmd.mv_start) begin
			mv_cur_q  <= mv_first;
			mv_end_q  <= mv_last;
			mv_down_q <= (kind_q == KIND_ALLOC);
			mv_dist_q <= mv_dist;
		end else if (mv_act_q) begin
			mv_cur_q <= mv_down_q ? mv_cur_q - PW'(1) : mv_cur_q + PW'(1);
		end
		wr_idx_s1 <= mv_down_q ? mv_cur_q + PW'(1) : mv_cur_q - PW'(mv_dist_q);
	end

	assign raddr = mv_act_q ? mv_cur_q[IDX_W-1:0] : ptr_q[IDX_W-1:0];
	assign we    = wr_pend_s1 || cmd.fix_a || cmd.fix_b;

	always_comb begin
		priority if (wr_pend_s1) begin
			waddr = wr_idx_s1[IDX_W-1:0];
			wdata = rdata;
		end else if (cmd.fix_b) begin
			waddr = hit_idx_q[IDX_W-1:0];
			wdata = fb_data;
		end else begin
			waddr = fa_idx[IDX_W-1:0];
			wdata = fa_data;
		end
	end

	ffba_ram #(.WIDTH(W), .DEPTH(TABLE_ENTRIES)) u_table (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign sts.kind      = kind_q;
	assign sts.req_zero  = (req_q == '0);
	assign sts.addr_zero = (baddr_q == '0);
	assign sts.full      = (count_q >= CNT_W'(TABLE_ENTRIES));
	assign sts.hit       = hit_now;
	assign sts.miss      = live_s1 && !vld_s1;
	assign sts.mv_done   = !mv_act_q && !wr_pend_s1;
	assign sts.need_b    = (kind_q == KIND_ALLOC) && split;

	assign address        = addr_q;
	assign status         = status_q;
	assign entries_in_use = USED_W'(count_q);
endmodule

@@ rtl/core/first_fit_block_allocator.sv @@
// Top level of the first-fit block allocator.
// An alloc or free request scans the table RAM one entry per cycle and, on a split or merge,
// shifts the table one entry per cycle before done.
// One request at a time; busy is high from accept until the done cycle.
// Reset: table holds one free block (0x1000, 65536); busy stays high after reset while S_INIT writes it.
// done is a one-cycle strobe; the receiver cannot stall.
module first_fit_block_allocator #(
	parameter int TABLE_ENTRIES = ffba_pkg::DEF_TABLE_ENTRIES,
	parameter int ADDR_BITS     = ffba_pkg::DEF_ADDR_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [ffba_pkg::KIND_W-1:0]    kind,
	input  logic [ffba_pkg::DATA_W-1:0]    request_size,
	input  logic [ffba_pkg::DATA_W-1:0]    block_address,
	output logic                           done,
	output logic [ffba_pkg::DATA_W-1:0]    address,
	output logic [ffba_pkg::STATUS_W-1:0]  status,
	output logic [ffba_pkg::USED_W-1:0]    entries_in_use,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [ffba_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ffba_pkg::DATA_W-1:0]    cfg_data
);
	import ffba_pkg::*;

	ffba_cmd_t cmd;
	ffba_sts_t sts;

	assign cfg_ready = 1'b1;

	ffba_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd),
		.sts    (sts)
	);

	ffba_dpath #(.TABLE_ENTRIES(TABLE_ENTRIES), .ADDR_BITS(ADDR_BITS)) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.kind           (kind),
		.request_size   (request_size),
		.block_address  (block_address),
		.cfg_we         (cfg_valid && cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.address        (address),
		.status         (status),
		.entries_in_use (entries_in_use)
	);
endmodule

@@ rtl/core/ffba_checker.sv @@
// Port-level checker of the first-fit block allocator and its bind.
module ffba_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           start,
	input logic                           busy,
	input logic                           done,
	input logic [ffba_pkg::DATA_W-1:0]    address,
	input logic [ffba_pkg::STATUS_W-1:0]  status
);
	import ffba_pkg::*;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result while busy");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("transaction accepted but not busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe longer than one cycle");

	a_fail_null: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_OK) |-> (address == '0)) else $error("failed result with address");
endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (.*);

@@ bench/first_fit_block_allocator_tb.sv @@
// Self-checking testbench for the first-fit block allocator: directed table, then random traffic.
`timescale 1ns / 100ps
module first_fit_block_allocator_tb;
	import ffba_pkg::*;

	localparam int NENT = DEF_TABLE_ENTRIES;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [KIND_W-1:0] kind;
	logic [DATA_W-1:0] request_size;
	logic [DATA_W-1:0] block_address;
	logic done;
	logic [DATA_W-1:0] address;
	logic [STATUS_W-1:0] status;
	logic [USED_W-1:0] entries_in_use;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DATA_W-1:0] cfg_data;

	first_fit_block_allocator dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .kind(kind),
		.request_size(request_size), .block_address(block_address), .done(done),
		.address(address), .status(status), .entries_in_use(entries_in_use),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	typedef struct packed {
		logic [DATA_W-1:0]   address;
		logic [STATUS_W-1:0] status;
		logic [USED_W-1:0]   used;
	} outcome_t;

	// allocator shadow
	logic [DATA_W-1:0] blk_start [NENT];
	logic [LEN_W-1:0]  blk_len [NENT];
	logic              blk_taken [NENT];
	int                blk_count;
	logic [DATA_W-1:0] shadow_base;
	logic [DATA_W-1:0] shadow_size;

	outcome_t pending_outcomes[$];
	int errors;
	int fed;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#20000000;
		$display("first_fit_block_allocator_tb: done, errors");
		$finish;
	end

	function automatic void rebuild_table();
		blk_start[0] = shadow_base;
		blk_len[0] = shadow_size;
		blk_taken[0] = 1'b0;
		blk_count = 1;
	endfunction

	function automatic void drop_entry(int k);
		for (int j = k; j + 1 < blk_count; j++) begin
			blk_start[j] = blk_start[j + 1];
			blk_len[j] = blk_len[j + 1];
			blk_taken[j] = blk_taken[j + 1];
		end
		blk_count--;
	endfunction

	function automatic outcome_t predict_allocator(logic [KIND_W-1:0] k,
			logic [DATA_W-1:0] req, logic [DATA_W-1:0] baddr);
		outcome_t r;
		logic [DATA_W:0] twice;
		int i;
		r = '0;
		r.status = ST_OK;
		if (k == KIND_ALLOC) begin
			if (req == 0) r.status = ST_ZERO;
			else if (blk_count >= NENT) r.status = ST_NOFIT;
			else begin
				r.status = ST_NOFIT;
				twice = {1'b0, req} << 1;
				for (i = 0; i < blk_count; i++) begin
					if (!blk_taken[i] && blk_len[i] >= req) break;
				end
				if (i < blk_count) begin
					r.status = ST_OK;
					r.address = blk_start[i];
					if ({1'b0, blk_len[i]} > twice) begin
						for (int j = blk_count; j > i + 1; j--) begin
							blk_start[j] = blk_start[j - 1];
							blk_len[j] = blk_len[j - 1];
							blk_taken[j] = blk_taken[j - 1];
						end
						blk_start[i + 1] = blk_start[i] + req;
						blk_len[i + 1] = blk_len[i] - req;
						blk_taken[i + 1] = 1'b0;
						blk_len[i] = req;
						blk_count++;
					end
					blk_taken[i] = 1'b1;
				end
			end
		end else if (k == KIND_FREE) begin
			if (baddr == 0) r.status = ST_ZERO;
			else begin
				r.status = ST_NOTFOUND;
				for (i = 0; i < blk_count; i++) begin
					if (blk_start[i] == baddr && blk_taken[i]) break;
				end
				if (i < blk_count) begin
					r.status = ST_OK;
					blk_taken[i] = 1'b0;
					if (i > 0 && !blk_taken[i - 1]) begin
						blk_len[i - 1] = blk_len[i - 1] + blk_len[i];
						drop_entry(i);
						i--;
					end
					if (i + 1 < blk_count && !blk_taken[i + 1]) begin
						blk_len[i] = blk_len[i] + blk_len[i + 1];
						drop_entry(i + 1);
					end
				end
			end
		end else if (k == KIND_INIT) begin
			rebuild_table();
		end
		r.used = USED_W'(blk_count);
		return r;
	endfunction

	// result monitor
	always @(posedge clk) begin
		outcome_t want;
		if (arst_n && done) begin
			if (pending_outcomes.size() == 0) begin
				$display("%0t: unexpected result addr=%h st=%0d used=%0d", $time,
					address, status, entries_in_use);
				errors++;
			end else begin
				want = pending_outcomes.pop_front();
				if (address !== want.address) begin
					$display("%0t: address exp %h got %h", $time, want.address, address);
					errors++;
				end
				if (status !== want.status) begin
					$display("%0t: status exp %0d got %0d", $time, want.status, status);
					errors++;
				end
				if (entries_in_use !== want.used) begin
					$display("%0t: entries_in_use exp %0d got %0d", $time, want.used,
						entries_in_use);
					errors++;
				end
			end
		end
	end

	task automatic send_request(logic [KIND_W-1:0] k, logic [DATA_W-1:0] req,
			logic [DATA_W-1:0] baddr);
		kind <= k;
		request_size <= req;
		block_address <= baddr;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		pending_outcomes.push_back(predict_allocator(k, req, baddr));
		fed++;
		@(negedge clk);
		start <= 1'b0;
		@(negedge clk);
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		while (pending_outcomes.size() != 0 && guard < 100000) begin
			@(negedge clk);
			guard++;
		end
		repeat (2 * NENT + 16) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_HEAP_BASE) shadow_base = val;
		else if (idx == REG_HEAP_SIZE) shadow_size = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	typedef struct {
		logic [KIND_W-1:0] k;
		logic [DATA_W-1:0] req;
		logic [DATA_W-1:0] baddr;
		bit                typed;
		outcome_t          want;
	} step_t;

	step_t directed_steps[] = '{
		'{KIND_ALLOC, 32'd0, 32'd0, 1'b1, '{32'd0, ST_ZERO, 7'd1}},
		'{KIND_FREE, 32'd0, 32'd0, 1'b1, '{32'd0, ST_ZERO, 7'd1}},
		'{KIND_FREE, 32'd0, 32'h1000, 1'b1, '{32'd0, ST_NOTFOUND, 7'd1}},
		'{KIND_ALLOC, 32'hFFFF_FFFF, 32'd0, 1'b1, '{32'd0, ST_NOFIT, 7'd1}},
		'{KIND_ALLOC, 32'd16, 32'd0, 1'b1, '{32'h1000, ST_OK, 7'd2}},
		'{KIND_ALLOC, 32'd100, 32'd0, 1'b0, '{32'd0, ST_OK, 7'd0}},
		'{KIND_ALLOC, 32'd40000, 32'd0, 1'b0, '{32'd0, ST_OK, 7'd0}},
		'{KIND_FREE, 32'd0, 32'h1010, 1'b0, '{32'd0, ST_OK, 7'd0}},
		'{KIND_FREE, 32'd0, 32'h1010, 1'b0, '{32'd0, ST_OK, 7'd0}},
		'{KIND_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '{32'd0, ST_OK, 7'd0}},
		'{KIND_FREE, 32'd0, 32'h1000, 1'b0, '{32'd0, ST_OK, 7'd0}},
		'{KIND_INIT, 32'd0, 32'd0, 1'b1, '{32'd0, ST_OK, 7'd1}},
		'{KIND_ALLOC, 32'h8000, 32'd0, 1'b1, '{32'h1000, ST_OK, 7'd1}},
		'{KIND_FREE, 32'd0, 32'h1000, 1'b1, '{32'd0, ST_OK, 7'd1}}
	};

	logic [DATA_W-1:0] live_blocks[$];

	task automatic random_item(int mode);
		int pick;
		logic [DATA_W-1:0] a;
		logic [DATA_W-1:0] sz;
		pick = $urandom_range(0, 99);
		if (pick < 50) begin
			case ($urandom_range(0, 3))
				0: sz = $urandom_range(1, 8);
				1: sz = $urandom_range(1, 600);
				2: sz = $urandom;
				default: sz = $urandom_range(0, 3000);
			endcase
			if (mode == 1) sz = $urandom_range(1, 4);
			send_request(KIND_ALLOC, sz, $urandom);
			if (pending_outcomes[$].status == ST_OK)
				live_blocks.push_back(pending_outcomes[$].address);
		end else if (pick < 85 && live_blocks.size() != 0) begin
			a = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
			send_request(KIND_FREE, $urandom, a);
		end else if (pick < 93) begin
			a = $urandom;
			if ($urandom_range(0, 3) == 0) a = 0;
			send_request(KIND_FREE, $urandom, a);
		end else if (pick < 97) begin
			send_request(KIND_INIT, $urandom, $urandom);
			live_blocks.delete();
		end else begin
			send_request(KIND_UNUSED, $urandom, $urandom);
		end
		// keep only addresses that still hold a taken block
		for (int q = live_blocks.size() - 1; q >= 0; q--) begin
			bit hit;
			hit = 0;
			for (int e = 0; e < blk_count; e++)
				if (blk_start[e] == live_blocks[q] && blk_taken[e]) hit = 1;
			if (!hit) live_blocks.delete(q);
		end
	endtask

	logic [DATA_W-1:0] bases[4] = '{32'h0, 32'hFFFF_FF00, 32'h0000_1000, 32'h8000_0000};
	logic [DATA_W-1:0] sizes[4] = '{32'h0, 32'hFFFF_FFFF, 32'd1, 32'd65536};

	initial begin
		int burst;
		errors = 0;
		fed = 0;
		start = 1'b0;
		kind = KIND_ALLOC;
		request_size = '0;
		block_address = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_HEAP_BASE;
		cfg_data = '0;
		arst_n = 1'b0;
		shadow_base = RESET_BASE;
		shadow_size = RESET_SIZE;
		rebuild_table();
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		foreach (directed_steps[n]) begin
			send_request(directed_steps[n].k, directed_steps[n].req, directed_steps[n].baddr);
			if (directed_steps[n].typed && pending_outcomes[$] != directed_steps[n].want) begin
				$display("%0t: directed row %0d predictor exp %h got %h", $time, n,
					directed_steps[n].want, pending_outcomes[$]);
				errors++;
			end
		end
		drain();

		for (int phase = 0; phase < 6; phase++) begin
			write_reg(REG_HEAP_BASE, phase < 4 ? bases[phase] : $urandom);
			write_reg(REG_HEAP_SIZE, phase < 4 ? sizes[phase] : $urandom_range(64, 200000));
			write_reg(4'd7, $urandom);
			send_request(KIND_INIT, 0, 0);
			live_blocks.delete();
			for (int n = 0; n < 150; ) begin
				burst = $urandom_range(1, 20);
				for (int b = 0; b < burst && n < 150; b++, n++)
					random_item(phase == 2 ? 1 : ($urandom_range(0, 9) == 0));
				if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 300)) @(negedge clk);
			end
			drain();
		end

		if (errors == 0)
			$display("first_fit_block_allocator_tb: done, clean");
		else
			$display("first_fit_block_allocator_tb: done, errors");
		$finish;
	end

endmodule
